// ----- sv/cdl_pkg.sv -----
// shared types and constants of the duty-cycle limiter
package cdl_pkg;

  localparam int TICK_W  = 32;
  localparam int TIME_W  = 48;
  localparam int WORK_W  = 20;
  localparam int LIM_W   = 7;
  localparam int TPS_W   = 14;
  localparam int STAT_W  = 2;
  localparam int Q_W     = 16;
  localparam int FRAC_W  = 14;
  localparam int NUM_W   = 72;
  localparam int DEN_W   = 62;
  localparam int MA_W    = 48;
  localparam int MB_W    = 32;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int QUO_W   = 22;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 20;
  // x/100 as (x*PCT_RCP) >> PCT_SH, exact for x below 2^30
  localparam int PCT_SH  = 33;

  localparam logic [MA_W-1:0]   US_PER_S   = MA_W'(1000000);
  localparam logic [MA_W-1:0]   US_PER_PCT = MA_W'(100000000);
  localparam logic [MB_W-1:0]   PCT_RCP    = MB_W'(85899346);
  localparam logic [WORK_W-1:0] Q_MAX      = WORK_W'(65535);
  localparam logic [LIM_W-1:0]  PCT_FULL   = LIM_W'(100);

  localparam logic [STAT_W-1:0] ST_FIRST = 2'd0;
  localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_GONE  = 2'd2;

  localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;
  localparam logic [IDX_W-1:0] REG_TPS    = 2'd2;

  typedef enum logic [4:0] {
    OP_START,
    OP_STORE,
    OP_CLEAR,
    OP_RDOLD,
    OP_DIFF,
    OP_HOLD,
    OP_FULLP,
    OP_MUL_USED_US,
    OP_MUL_DT_TPS,
    OP_DIV_USAGE,
    OP_DIV_RATE,
    OP_MUL_PL,
    OP_MUL_NUM_TPS,
    OP_MUL_NUM_SUM,
    OP_MUL_USED_PCT,
    OP_DIV_SLICE,
    OP_RCP_FIRST_SLICE,
    OP_RCP_FIRST_USE,
    OP_ADV,
    OP_SUBW,
    OP_DONE
  } op_t;

  typedef struct packed {
    logic accept;
    logic go;
    op_t  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic alive;
    logic first;
    logic full;
    logic dt_zero;
    logic used_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/cdl_mul.sv -----
// serial multiplier, one 48x16 partial product per cycle, low half of b first
module cdl_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cdl_pkg::MA_W-1:0]   a,
  input  logic [cdl_pkg::MB_W-1:0]   b,
  output logic                       busy,
  output logic                       done,
  output logic [cdl_pkg::PROD_W-1:0] prod
);

  logic [cdl_pkg::MA_W-1:0]        a_q;
  logic [cdl_pkg::MB_W-1:0]        b_q;
  logic                            hi;
  logic [15:0]                     chunk;
  logic [cdl_pkg::MA_W+15:0]       part;

  assign chunk = hi ? b_q[31:16] : b_q[15:0];
  assign part  = a_q * chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      hi   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        hi   <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!hi) begin
          prod <= cdl_pkg::PROD_W'(part);
          hi   <= 1'b1;
        end else begin
          prod <= prod + {part, 16'b0};
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/cdl_div.sv -----
// restoring divider, one quotient bit per cycle
module cdl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cdl_pkg::NUM_W-1:0] dividend,
  input  logic [cdl_pkg::DEN_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [cdl_pkg::QUO_W-1:0] quot
);

  localparam int SH_W = cdl_pkg::DEN_W + cdl_pkg::QUO_W;

  logic [cdl_pkg::NUM_W-1:0] rem;
  logic [SH_W-1:0]           dsh;
  logic [4:0]                cnt;
  logic                      ge;

  assign ge = {{(SH_W-cdl_pkg::NUM_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsh  <= {1'b0, divisor, {(cdl_pkg::QUO_W-1){1'b0}}};
        quot <= '0;
        cnt  <= 5'(cdl_pkg::QUO_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) rem <= rem - dsh[cdl_pkg::NUM_W-1:0];
        quot <= {quot[cdl_pkg::QUO_W-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/cdl_ctrl.sv -----
// sequencer that steps the datapath through one sample
module cdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdl_pkg::dp_stat_t stat,
  output cdl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_t;

  state_t         state;
  cdl_pkg::op_t   op;
  cdl_pkg::op_t   nxt;

  function automatic cdl_pkg::op_t next_op(cdl_pkg::op_t cur, cdl_pkg::dp_stat_t s);
    cdl_pkg::op_t r;
    r = cdl_pkg::OP_DONE;
    case (cur)
      cdl_pkg::OP_START:         r = s.alive ? cdl_pkg::OP_STORE : cdl_pkg::OP_CLEAR;
      cdl_pkg::OP_STORE:         r = s.first ? cdl_pkg::OP_MUL_PL : cdl_pkg::OP_RDOLD;
      cdl_pkg::OP_RDOLD:         r = cdl_pkg::OP_DIFF;
      cdl_pkg::OP_DIFF:          r = s.dt_zero ? cdl_pkg::OP_HOLD : cdl_pkg::OP_MUL_USED_US;
      cdl_pkg::OP_HOLD,
      cdl_pkg::OP_FULLP,
      cdl_pkg::OP_DIV_SLICE:     r = s.full ? cdl_pkg::OP_ADV : cdl_pkg::OP_DONE;
      cdl_pkg::OP_MUL_USED_US:   r = cdl_pkg::OP_MUL_DT_TPS;
      cdl_pkg::OP_MUL_DT_TPS:    r = cdl_pkg::OP_DIV_USAGE;
      cdl_pkg::OP_DIV_USAGE:     r = cdl_pkg::OP_DIV_RATE;
      cdl_pkg::OP_DIV_RATE:      r = s.used_zero ? cdl_pkg::OP_FULLP : cdl_pkg::OP_MUL_PL;
      cdl_pkg::OP_MUL_PL:        r = s.first ? cdl_pkg::OP_RCP_FIRST_SLICE
                                             : cdl_pkg::OP_MUL_NUM_TPS;
      cdl_pkg::OP_MUL_NUM_TPS:   r = cdl_pkg::OP_MUL_NUM_SUM;
      cdl_pkg::OP_MUL_NUM_SUM:   r = cdl_pkg::OP_MUL_USED_PCT;
      cdl_pkg::OP_MUL_USED_PCT:  r = cdl_pkg::OP_DIV_SLICE;
      cdl_pkg::OP_RCP_FIRST_SLICE: r = cdl_pkg::OP_RCP_FIRST_USE;
      cdl_pkg::OP_ADV:           r = cdl_pkg::OP_SUBW;
      default:                   r = cdl_pkg::OP_DONE;
    endcase
    return r;
  endfunction

  assign nxt      = next_op(op, stat);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.go       = (state == S_ISSUE);
    cmd.op       = op;
    cmd.load_out = (state == S_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= cdl_pkg::OP_START;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= cdl_pkg::OP_START;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (!stat.busy) begin
            if (nxt == cdl_pkg::OP_DONE) begin
              state <= S_FINISH;
            end else begin
              op    <= nxt;
              state <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/cdl_dp.sv -----
// datapath: sample window, config registers, arithmetic units and result register
module cdl_dp #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cdl_pkg::dp_cmd_t              cmd,
  output cdl_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [cdl_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [cdl_pkg::CFG_W-1:0]     cfg_val,
  input  logic                          in_alive,
  input  logic [cdl_pkg::TICK_W-1:0]    in_ticks,
  input  logic [cdl_pkg::TIME_W-1:0]    in_time,
  input  logic [cdl_pkg::WORK_W-1:0]    in_work,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdl_pkg::STAT_W-1:0]    out_status,
  output logic [cdl_pkg::WORK_W-1:0]    out_work,
  output logic [cdl_pkg::WORK_W-1:0]    out_sleep,
  output logic [cdl_pkg::Q_W-1:0]       out_usage,
  output logic [cdl_pkg::Q_W-1:0]       out_rate,
  output logic                          out_resume,
  output logic                          out_stop
);

  localparam int PW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = cdl_pkg::WORK_W + $clog2(WINDOW_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(WINDOW_DEPTH);

  typedef struct packed {
    logic [cdl_pkg::TICK_W-1:0] tick;
    logic [cdl_pkg::TIME_W-1:0] tm;
    logic [cdl_pkg::WORK_W-1:0] work;
  } entry_t;

  entry_t ring [WINDOW_DEPTH];
  entry_t rd;

  logic [cdl_pkg::LIM_W-1:0]  limit;
  logic [cdl_pkg::WORK_W-1:0] period;
  logic [cdl_pkg::TPS_W-1:0]  tps;
  logic [cdl_pkg::TPS_W-1:0]  tps_eff;

  logic                       alive;
  entry_t                     smp;
  logic [PW-1:0]              wptr;
  logic [PW-1:0]              optr;
  logic [PW-1:0]              optr_inc;
  logic [CW-1:0]              cnt;
  logic [SUM_W-1:0]           wsum;
  logic [cdl_pkg::TIME_W-1:0] dt;
  logic [cdl_pkg::TICK_W-1:0] used;
  logic [cdl_pkg::NUM_W-1:0]  num;
  logic [cdl_pkg::DEN_W-1:0]  den;
  logic [cdl_pkg::WORK_W-1:0] slice;
  logic [cdl_pkg::WORK_W-1:0] held;
  logic [cdl_pkg::Q_W-1:0]    usage;
  logic [cdl_pkg::Q_W-1:0]    rate;
  logic [cdl_pkg::STAT_W-1:0] status;
  cdl_pkg::op_t               pend;

  logic                        mul_start, mul_busy, mul_done;
  logic [cdl_pkg::MA_W-1:0]    mul_a;
  logic [cdl_pkg::MB_W-1:0]    mul_b;
  logic [cdl_pkg::PROD_W-1:0]  prod;
  logic                        div_start, div_busy, div_done;
  logic [cdl_pkg::NUM_W-1:0]   div_n;
  logic [cdl_pkg::DEN_W-1:0]   div_d;
  logic [cdl_pkg::QUO_W-1:0]   quot;
  logic [cdl_pkg::WORK_W-1:0]  cap;
  logic [cdl_pkg::WORK_W-1:0]  capped;
  logic [cdl_pkg::QUO_W-1:0]   rcp_q;
  logic                        rd_en;
  logic [PW-1:0]               rd_addr;

  assign tps_eff  = (tps == '0) ? cdl_pkg::TPS_W'(1) : tps;
  assign optr_inc = (optr == LAST) ? '0 : optr + PW'(1);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd.op)
      cdl_pkg::OP_MUL_USED_US: begin
        mul_start = cmd.go;
        mul_a = cdl_pkg::US_PER_S;
        mul_b = used;
      end
      cdl_pkg::OP_MUL_DT_TPS: begin
        mul_start = cmd.go;
        mul_a = dt;
        mul_b = cdl_pkg::MB_W'(tps_eff);
      end
      cdl_pkg::OP_MUL_PL: begin
        mul_start = cmd.go;
        mul_a = cdl_pkg::MA_W'(period);
        mul_b = cdl_pkg::MB_W'(limit);
      end
      cdl_pkg::OP_MUL_NUM_TPS: begin
        mul_start = cmd.go;
        mul_a = num[cdl_pkg::MA_W-1:0];
        mul_b = cdl_pkg::MB_W'(tps_eff);
      end
      cdl_pkg::OP_MUL_NUM_SUM: begin
        mul_start = cmd.go;
        mul_a = num[cdl_pkg::MA_W-1:0];
        mul_b = cdl_pkg::MB_W'(wsum);
      end
      cdl_pkg::OP_MUL_USED_PCT: begin
        mul_start = cmd.go;
        mul_a = cdl_pkg::US_PER_PCT;
        mul_b = used;
      end
      // first sample divides by hundred through a reciprocal product
      cdl_pkg::OP_RCP_FIRST_SLICE: begin
        mul_start = cmd.go;
        mul_a = num[cdl_pkg::MA_W-1:0];
        mul_b = cdl_pkg::PCT_RCP;
      end
      cdl_pkg::OP_RCP_FIRST_USE: begin
        mul_start = cmd.go;
        mul_a = cdl_pkg::MA_W'(limit) << cdl_pkg::FRAC_W;
        mul_b = cdl_pkg::PCT_RCP;
      end
      cdl_pkg::OP_DIV_USAGE: begin
        div_start = cmd.go;
        div_n = num << cdl_pkg::FRAC_W;
        div_d = den;
      end
      cdl_pkg::OP_DIV_RATE: begin
        div_start = cmd.go;
        div_n = cdl_pkg::NUM_W'(wsum) << cdl_pkg::FRAC_W;
        div_d = cdl_pkg::DEN_W'(dt);
      end
      cdl_pkg::OP_DIV_SLICE: begin
        div_start = cmd.go;
        div_n = num;
        div_d = den;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  cdl_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  cdl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  // slice results saturate at the period, usage and rate results at the top of Q2.14
  assign cap = (pend == cdl_pkg::OP_DIV_SLICE) ? period : cdl_pkg::Q_MAX;
  assign capped = (quot > cdl_pkg::QUO_W'(cap)) ? cap : quot[cdl_pkg::WORK_W-1:0];
  assign rcp_q  = prod[cdl_pkg::PCT_SH +: cdl_pkg::QUO_W];

  assign stat.busy      = mul_busy | mul_done | div_busy | div_done;
  assign stat.alive     = alive;
  assign stat.first     = (cnt == CW'(1));
  assign stat.full      = (cnt == FULL);
  assign stat.dt_zero   = (dt == '0);
  assign stat.used_zero = (used == '0);
  assign stat.out_free  = !out_valid || out_ready;

  assign rd_en   = cmd.go && (cmd.op == cdl_pkg::OP_RDOLD || cmd.op == cdl_pkg::OP_ADV);
  assign rd_addr = (cmd.op == cdl_pkg::OP_ADV) ? optr_inc : optr;

  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == cdl_pkg::OP_STORE) ring[wptr] <= smp;
    if (rd_en) rd <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= cdl_pkg::PCT_FULL;
      period    <= cdl_pkg::WORK_W'(100000);
      tps       <= cdl_pkg::TPS_W'(100);
      wptr      <= '0;
      optr      <= '0;
      cnt       <= '0;
      wsum      <= '0;
      held      <= '0;
      out_valid <= 1'b0;
      pend      <= cdl_pkg::OP_START;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          cdl_pkg::REG_LIMIT:  limit  <= cfg_val[cdl_pkg::LIM_W-1:0];
          cdl_pkg::REG_PERIOD: period <= cfg_val[cdl_pkg::WORK_W-1:0];
          cdl_pkg::REG_TPS:    tps    <= cfg_val[cdl_pkg::TPS_W-1:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        alive    <= in_alive;
        smp.tick <= in_ticks;
        smp.tm   <= in_time;
        smp.work <= in_work;
      end

      if (mul_start || div_start) pend <= cmd.op;

      if (cmd.go) begin
        case (cmd.op)
          cdl_pkg::OP_STORE: begin
            wptr   <= (wptr == LAST) ? '0 : wptr + PW'(1);
            cnt    <= cnt + CW'(1);
            wsum   <= (cnt == '0) ? '0 : wsum + SUM_W'(smp.work);
            status <= (cnt == '0) ? cdl_pkg::ST_FIRST : cdl_pkg::ST_VALID;
          end
          cdl_pkg::OP_CLEAR: begin
            wptr   <= '0;
            optr   <= '0;
            cnt    <= '0;
            wsum   <= '0;
            status <= cdl_pkg::ST_GONE;
          end
          cdl_pkg::OP_DIFF: begin
            dt   <= smp.tm - rd.tm;
            used <= smp.tick - rd.tick;
          end
          cdl_pkg::OP_HOLD: begin
            slice <= (held > period) ? period : held;
            usage <= (used != '0) ? cdl_pkg::Q_MAX[cdl_pkg::Q_W-1:0] : '0;
            rate  <= (wsum != '0) ? cdl_pkg::Q_MAX[cdl_pkg::Q_W-1:0] : '0;
          end
          cdl_pkg::OP_FULLP: slice <= period;
          cdl_pkg::OP_ADV: begin
            optr <= optr_inc;
            cnt  <= cnt - CW'(1);
          end
          // the new oldest entry leaves the work sum
          cdl_pkg::OP_SUBW: wsum <= wsum - SUM_W'(rd.work);
          default: ;
        endcase
      end

      if (mul_done) begin
        case (pend)
          cdl_pkg::OP_MUL_DT_TPS,
          cdl_pkg::OP_MUL_USED_PCT: den <= prod[cdl_pkg::DEN_W-1:0];
          cdl_pkg::OP_RCP_FIRST_SLICE:
            slice <= (rcp_q > cdl_pkg::QUO_W'(period)) ? period
                                                       : rcp_q[cdl_pkg::WORK_W-1:0];
          cdl_pkg::OP_RCP_FIRST_USE: begin
            usage <= rcp_q[cdl_pkg::Q_W-1:0];
            rate  <= rcp_q[cdl_pkg::Q_W-1:0];
          end
          default:                  num <= prod[cdl_pkg::NUM_W-1:0];
        endcase
      end

      if (div_done) begin
        case (pend)
          cdl_pkg::OP_DIV_USAGE: usage <= capped[cdl_pkg::Q_W-1:0];
          cdl_pkg::OP_DIV_RATE:  rate  <= capped[cdl_pkg::Q_W-1:0];
          default: slice <= capped;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        out_status <= status;
        if (status == cdl_pkg::ST_GONE) begin
          out_work   <= '0;
          out_sleep  <= '0;
          out_usage  <= '0;
          out_rate   <= '0;
          out_resume <= 1'b0;
          out_stop   <= 1'b0;
        end else begin
          held       <= slice;
          out_work   <= slice;
          out_sleep  <= period - slice;
          out_usage  <= usage;
          out_rate   <= rate;
          out_resume <= (limit != '0) && (limit < cdl_pkg::PCT_FULL);
          out_stop   <= (limit < cdl_pkg::PCT_FULL);
        end
      end
    end
  end

endmodule

// ----- sv/cpu_duty_cycle_limiter_unit.sv -----
// top level of the duty-cycle limiter
// One item is one sample of the controlled process, one result item per sample gives the
// work and sleep slices for the next period plus Q2.14 usage and working-rate estimates.
// Samples are handled one at a time, the next item taken only once the last is finished. A
// gone process, a first sample, a zero time step and a full estimate each take their own
// sequence of steps; the last two also drop the oldest window entry once the window is full.
// A full estimate uses the serial divider (three divisions) and the multiplier (six products)
// that a sequencer drives in turn. A finished result waits in an output register while the
// next sample is taken; the sequencer holds in its last step while that register is still
// unread. Config writes are taken at any time and must come while idle.
module cpu_duty_cycle_limiter_unit #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // process_ticks, time_us, last_work_us, zero pad
  input  logic [0:0]   s_tuser,   // process_alive
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // work_slice_us, sleep_slice_us, usage estimate,
                                  // working_rate, resume_process, stop_process, zero pad
  output logic [1:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  cdl_pkg::dp_cmd_t  cmd;
  cdl_pkg::dp_stat_t stat;

  logic [cdl_pkg::WORK_W-1:0] work, sleep;
  logic [cdl_pkg::Q_W-1:0]    usage, rate;
  logic                       resume, stop;

  assign cfg_ready = 1'b1;

  cdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdl_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .in_alive   (s_tuser[0]),
    .in_ticks   (s_tdata[31:0]),
    .in_time    (s_tdata[79:32]),
    .in_work    (s_tdata[99:80]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_work   (work),
    .out_sleep  (sleep),
    .out_usage  (usage),
    .out_rate   (rate),
    .out_resume (resume),
    .out_stop   (stop)
  );

  assign m_tdata = {6'b0, stop, resume, rate, usage, sleep, work};

endmodule
